// ----- rtl/key_index_quicksort_assert.svh -----
// Assertion macros for the key/index sorter
`ifndef KEY_INDEX_QUICKSORT_ASSERT_SVH
`define KEY_INDEX_QUICKSORT_ASSERT_SVH
// assert that a condition implies another in the same cycle
`define KIQ_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// assert that a condition implies another in the next cycle
`define KIQ_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// ----- rtl/kiq_pkg.sv -----
// ----------------------------------------------------------------------------
// kiq_pkg
// Shared types of the key/index sorter.
// ----------------------------------------------------------------------------
package kiq_pkg;
	localparam int KEY_W = 32;
	localparam int IDX_W = 16;
	localparam int PTR_W = 6;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [IDX_W-1:0] item_index;
		logic final_item;
	} in_item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] sorted_key;
		logic [IDX_W-1:0] sorted_index;
		logic last_result;
		logic overflow;
	} out_item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [IDX_W-1:0] idx;
	} pair_t;
endpackage

// ----- rtl/key_index_quicksort.sv -----
// ----------------------------------------------------------------------------
// key_index_quicksort
// Collects key/index pairs, sorts them with a first-element-pivot quicksort
// held in RAM, and emits them in ascending key order.
// ----------------------------------------------------------------------------
// channel | direction | payload     | handshake
// in      | input     | in_item_t   | in_valid / in_stall
// out     | output    | out_item_t  | out_valid / out_stall
// Loading takes one transfer per cycle.
// After the final item the sort runs from the pair RAM, comparing keys and
// swapping pairs, with ranges popped from the range RAM.
// Unloading reads the pair RAM for each result after the previous one transfers.
// Reset clears the state, item count, stack pointer and flags; RAM contents need no reset.
// Input stalls from the final item until the last result transfers.
module key_index_quicksort
	import kiq_pkg::*;
#(
	parameter int MAX_ITEMS = 64
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data
);
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	typedef enum logic [4:0] {
		LOAD, POP, POPW, PIV, PIVW, RSCAN, RSCANW, LSCAN, LSCANW, SWPA, SWPB,
		FINW, FIN, PUSH1, PUSH2, OUTR, OUTW, OUTH
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic drop_q;
	logic [AW-1:0] lo_q, hi_q, l_q, r_q, b_q, oi_q;
	logic [PTR_W:0] sp_q;
	logic signed [KEY_W-1:0] piv_q;
	logic [IDX_W-1:0] piv_idx_q;
	logic pswap_q;
	pair_t pa_q, pb_q;
	out_item_t out_q;
	logic ov_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	pair_t wdata, rdata;
	logic swe;
	logic [PTR_W-1:0] saddr_w, saddr_r;
	logic [2*PTR_W-1:0] sw, sr;

	kiq_ram #(.WIDTH(KEY_W + IDX_W), .DEPTH(MAX_ITEMS)) u_pairs (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr),
		.rdata(rdata)
	);
	kiq_ram #(.WIDTH(2 * PTR_W), .DEPTH(64)) u_stack (
		.clk(clk), .we(swe), .waddr(saddr_w), .wdata(sw), .raddr(saddr_r),
		.rdata(sr)
	);

	assign in_stall = (state_q != LOAD);
	assign out_valid = (state_q == OUTH);
	assign out_data = out_q;

	logic [PTR_W-1:0] lo_r, hi_r;
	assign lo_r = sr[2*PTR_W-1:PTR_W];
	assign hi_r = sr[PTR_W-1:0];

	always_comb begin
		we = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = '{key: in_data.key, idx: in_data.item_index};
		raddr = r_q;
		swe = 1'b0;
		saddr_w = sp_q[PTR_W-1:0];
		sw = '0;
		saddr_r = PTR_W'(sp_q - 1'b1);
		case (state_q)
			LOAD: begin
				we = in_valid && (cnt_q < CW'(MAX_ITEMS));
				if (in_valid && in_data.final_item && cnt_q >= CW'(1)) begin
					swe = 1'b1;
					saddr_w = '0;
					sw = {PTR_W'(0), PTR_W'(cnt_q - CW'(1)
						+ CW'(in_data.final_item && cnt_q < CW'(MAX_ITEMS)))};
				end
			end
			PIV: raddr = lo_q;
			RSCAN, RSCANW: raddr = r_q;
			LSCAN, LSCANW: raddr = l_q;
			SWPA: begin
				we = 1'b1;
				waddr = l_q;
				wdata = pb_q;
			end
			SWPB: begin
				we = 1'b1;
				waddr = r_q;
				wdata = pa_q;
			end
			FINW, FIN: raddr = l_q;
			PUSH1: begin
				if (CW'(b_q) - CW'(lo_q) >= CW'(2)) begin
					swe = 1'b1;
					sw = {PTR_W'(lo_q), PTR_W'(b_q - 1'b1)};
				end
			end
			PUSH2: begin
				if (CW'(hi_q) - CW'(b_q) >= CW'(2)) begin
					swe = 1'b1;
					sw = {PTR_W'(b_q + 1'b1), PTR_W'(hi_q)};
				end
			end
			OUTR, OUTW, OUTH: raddr = oi_q;
			default: ;
		endcase
	end

	// Partition runs in the pair RAM: pa/pb hold the left and right pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= LOAD;
			cnt_q <= '0;
			drop_q <= 1'b0;
			sp_q <= '0;
			ov_q <= 1'b0;
			pswap_q <= 1'b0;
		end else begin
			case (state_q)
				LOAD: begin
					if (in_valid) begin
						if (cnt_q < CW'(MAX_ITEMS)) begin
							cnt_q <= cnt_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
						if (in_data.final_item) begin
							ov_q <= drop_q || (cnt_q >= CW'(MAX_ITEMS));
							oi_q <= '0;
							if (cnt_q >= CW'(1)) begin
								sp_q <= (PTR_W+1)'(1);
								state_q <= POP;
							end else begin
								state_q <= OUTR;
							end
						end
					end
				end
				POP: begin
					if (sp_q == '0) begin
						state_q <= OUTR;
					end else begin
						state_q <= POPW;
					end
				end
				POPW: begin
					sp_q <= sp_q - 1'b1;
					lo_q <= AW'(lo_r);
					hi_q <= AW'(hi_r);
					l_q <= AW'(lo_r) + 1'b1;
					r_q <= AW'(hi_r);
					pswap_q <= 1'b0;
					if (lo_r >= hi_r) begin
						state_q <= POP;
					end else begin
						state_q <= PIV;
					end
				end
				PIV: state_q <= PIVW;
				PIVW: begin
					piv_q <= rdata.key;
					piv_idx_q <= rdata.idx;
					state_q <= RSCAN;
				end
				RSCAN: state_q <= RSCANW;
				RSCANW: begin
					if (l_q >= r_q) begin
						state_q <= FINW;
					end else if (rdata.key >= piv_q) begin
						r_q <= r_q - 1'b1;
						state_q <= RSCAN;
					end else begin
						pb_q <= rdata;
						state_q <= LSCAN;
					end
				end
				LSCAN: state_q <= LSCANW;
				LSCANW: begin
					if (l_q >= r_q) begin
						state_q <= FINW;
					end else if (rdata.key < piv_q) begin
						l_q <= l_q + 1'b1;
						state_q <= LSCAN;
					end else begin
						pa_q <= rdata;
						state_q <= SWPA;
					end
				end
				SWPA: state_q <= SWPB;
				SWPB: begin
					if (pswap_q) begin
						pswap_q <= 1'b0;
						state_q <= PUSH1;
					end else begin
						state_q <= RSCAN;
					end
				end
				FINW: state_q <= FIN;
				FIN: begin
					if (rdata.key >= piv_q) begin
						b_q <= lo_q;
						state_q <= PUSH1;
					end else begin
						// swap pivot pair into the meeting point
						b_q <= l_q;
						pb_q <= rdata;
						pa_q <= '{key: piv_q, idx: piv_idx_q};
						l_q <= lo_q;
						r_q <= l_q;
						pswap_q <= 1'b1;
						state_q <= SWPA;
					end
				end
				PUSH1: begin
					if (CW'(b_q) - CW'(lo_q) >= CW'(2)) sp_q <= sp_q + 1'b1;
					state_q <= PUSH2;
				end
				PUSH2: begin
					if (CW'(hi_q) - CW'(b_q) >= CW'(2)) sp_q <= sp_q + 1'b1;
					state_q <= POP;
				end
				OUTR: state_q <= OUTW;
				OUTW: begin
					out_q.sorted_key <= rdata.key;
					out_q.sorted_index <= rdata.idx;
					out_q.last_result <= (CW'(oi_q) + 1'b1 == cnt_q);
					out_q.overflow <= ov_q;
					state_q <= OUTH;
				end
				OUTH: begin
					if (!out_stall) begin
						if (CW'(oi_q) + 1'b1 == cnt_q) begin
							cnt_q <= '0;
							drop_q <= 1'b0;
							state_q <= LOAD;
						end else begin
							oi_q <= oi_q + 1'b1;
							state_q <= OUTR;
						end
					end
				end
				default: state_q <= LOAD;
			endcase
		end
	end
endmodule

// ----- rtl/kiq_ram.sv -----
// ----------------------------------------------------------------------------
// kiq_ram
// Generic single-port-write, one-read RAM with registered read.
// ----------------------------------------------------------------------------
module kiq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- rtl/kiq_checker.sv -----
// ----------------------------------------------------------------------------
// kiq_checker
// Port-level checks of the key/index sorter.
// ----------------------------------------------------------------------------
`include "key_index_quicksort_assert.svh"
module kiq_checker
	import kiq_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input in_item_t in_data,
	input logic out_valid,
	input logic out_stall,
	input out_item_t out_data
);
	`KIQ_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_data))
	`KIQ_ASSERT_IMPL(a_exclusive, clk, arst_n, out_valid, in_stall)
	`KIQ_ASSERT_NEXT(a_fin, clk, arst_n, in_valid && !in_stall && in_data.final_item, in_stall)
endmodule

bind key_index_quicksort kiq_checker u_kiq_checker (.*);
